### rtl/core/csm_pkg.sv
`default_nettype none

package csm_pkg;

  // Field widths of the command and result transactions.
  localparam int CMD_W   = 3;
  localparam int SLOT_W  = 4;
  localparam int ELEM_W  = 8;
  localparam int IDX_W   = 5;
  localparam int LIMIT_W = 5;
  localparam int CROW_W  = 2;
  localparam int CCOL_W  = 2;
  localparam int CVAL_W  = 8;

  // Default sizing of the unit.
  localparam int DIM_DEF          = 4;
  localparam int ELEM_BITS_DEF    = 8;
  localparam int MAX_NONZEROS_DEF = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_B = 3'd0,
    CMD_WR_C = 3'd1,
    CMD_PTR  = 3'd2,
    CMD_ROW  = 3'd3,
    CMD_VAL  = 3'd4,
    CMD_RUN  = 3'd5
  } cmd_t;

endpackage

`default_nettype wire

### rtl/core/csm_if.sv
`default_nettype none

interface csm_in_if;
  logic                              valid;
  logic                              ready;
  logic [csm_pkg::CMD_W-1:0]         cmd;
  logic [csm_pkg::SLOT_W-1:0]        slot;
  logic signed [csm_pkg::ELEM_W-1:0] element_value;
  logic [csm_pkg::IDX_W-1:0]         index_value;
  logic [csm_pkg::LIMIT_W-1:0]       nonzero_limit;

  modport source (output valid, cmd, slot, element_value, index_value, nonzero_limit,
                  input ready);
  modport sink (input valid, cmd, slot, element_value, index_value, nonzero_limit,
                output ready);
endinterface

interface csm_out_if;
  logic                              valid;
  logic                              ready;
  logic [csm_pkg::CROW_W-1:0]        c_row;
  logic [csm_pkg::CCOL_W-1:0]        c_col;
  logic signed [csm_pkg::CVAL_W-1:0] c_value;
  logic                              last;

  modport source (output valid, c_row, c_col, c_value, last, input ready);
  modport sink (input valid, c_row, c_col, c_value, last, output ready);
endinterface

`default_nettype wire

### rtl/core/csm_c_store.sv
`default_nettype none

// Accumulator store for C with a registered read port. Each entry carries a
// valid bit, cleared by reset, so that an entry not yet written reads as zero.
module csm_c_store #(
  parameter int DIM       = csm_pkg::DIM_DEF,
  parameter int ELEM_BITS = csm_pkg::ELEM_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            wr_en,
  input  wire logic [$clog2(DIM*DIM)-1:0]      wr_addr,
  input  wire logic [ELEM_BITS-1:0]            wr_data,
  input  wire logic [$clog2(DIM*DIM)-1:0]      rd_addr,
  output logic      [ELEM_BITS-1:0]            rd_data
);

  localparam int ElemCnt = DIM * DIM;

  logic [ELEM_BITS-1:0] mem [ElemCnt];
  logic [ElemCnt-1:0]   vld_r;
  logic [ELEM_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/core/csc_sparse_dense_matmul_unit.sv
`default_nettype none

// Sparse (compressed-sparse-column) times dense matrix multiply-accumulate,
// C += A * B, with one shared multiplier and a C accumulator store with one
// read and one write port. Load commands (B, C, column pointer, row index,
// nonzero value) are accepted while idle. A run command walks the columns,
// loads each nonzero visited, and for every nonzero whose row is in range
// does one read, one multiply and one accumulate per element of the B row;
// it then emits the DIM*DIM elements of C in row-major order, each read and
// then held until the consumer takes it; last marks the final element. The
// multiply-accumulate loop through the C store port sets the run time. The
// input is not ready while a run is in progress. C keeps its contents between
// runs; after reset it reads as zero with no clearing pass.
module csc_sparse_dense_matmul_unit #(
  parameter int DIM          = csm_pkg::DIM_DEF,
  parameter int ELEM_BITS    = csm_pkg::ELEM_BITS_DEF,
  parameter int MAX_NONZEROS = csm_pkg::MAX_NONZEROS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  csm_in_if.sink    in_ch,
  csm_out_if.source out_ch
);

  localparam int ElemCnt = DIM * DIM;
  localparam int CIdxW   = $clog2(ElemCnt);
  localparam int RowW    = $clog2(DIM);
  localparam int PtrCnt  = DIM + 1;
  localparam int PtrIdxW = $clog2(PtrCnt);
  localparam int NzIdxW  = $clog2(MAX_NONZEROS);
  localparam logic [csm_pkg::IDX_W-1:0] DimIdx = csm_pkg::IDX_W'(DIM);

  typedef enum logic [3:0] {
    S_IDLE,
    S_COL,
    S_END,
    S_NZ,
    S_LOAD,
    S_RD,
    S_MUL,
    S_ACC,
    S_ERD,
    S_EOUT
  } state_t;

  state_t state_r;

  // Input decode.
  logic                            in_acc;
  logic [ELEM_BITS-1:0]            elem_in;
  logic [csm_pkg::LIMIT_W-1:0]     lim_in;
  logic                            slot_ok_elem;
  logic                            slot_ok_ptr;
  logic                            slot_ok_nz;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign elem_in      = ELEM_BITS'(in_ch.element_value);
  assign slot_ok_elem = 32'(in_ch.slot) < ElemCnt;
  assign slot_ok_ptr  = 32'(in_ch.slot) < PtrCnt;
  assign slot_ok_nz   = 32'(in_ch.slot) < MAX_NONZEROS;
  assign lim_in = (32'(in_ch.nonzero_limit) > MAX_NONZEROS) ?
                  csm_pkg::LIMIT_W'(MAX_NONZEROS) : in_ch.nonzero_limit;

  // Sequencer registers.
  logic [PtrIdxW-1:0]           k_r;
  logic [csm_pkg::IDX_W-1:0]    nz_r;
  logic [csm_pkg::IDX_W-1:0]    end_r;
  logic [csm_pkg::LIMIT_W-1:0]  lim_r;
  logic [RowW-1:0]              j_r;
  logic [RowW-1:0]              row_r;
  logic [ELEM_BITS-1:0]         a_r;
  logic [ELEM_BITS-1:0]         prod_r;
  logic [RowW-1:0]              e_row_r;
  logic [RowW-1:0]              e_col_r;

  // Result register.
  logic                         out_valid_r;
  logic [csm_pkg::CROW_W-1:0]   c_row_r;
  logic [csm_pkg::CCOL_W-1:0]   c_col_r;
  logic [csm_pkg::CVAL_W-1:0]   c_value_r;
  logic                         last_r;

  // Pointer store: small, read at one address at a time.
  logic [csm_pkg::IDX_W-1:0] ptr_r [PtrCnt];
  logic [PtrIdxW-1:0]        ptr_addr;
  logic [csm_pkg::IDX_W-1:0] ptr_rd;

  assign ptr_addr = (state_r == S_END) ? k_r + PtrIdxW'(1) : k_r;
  assign ptr_rd   = ptr_r[ptr_addr];

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.cmd == csm_pkg::CMD_PTR && slot_ok_ptr) begin
      ptr_r[PtrIdxW'(in_ch.slot)] <= in_ch.index_value;
    end
  end

  // B store.
  logic [ELEM_BITS-1:0] b_mem [ElemCnt];
  logic [ELEM_BITS-1:0] b_rd_r;
  logic [CIdxW-1:0]     b_addr;

  assign b_addr = CIdxW'(k_r * DIM + j_r);

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.cmd == csm_pkg::CMD_WR_B && slot_ok_elem) begin
      b_mem[CIdxW'(in_ch.slot)] <= elem_in;
    end
    b_rd_r <= b_mem[b_addr];
  end

  // Row index and nonzero value stores, both read at the current nonzero.
  logic [csm_pkg::IDX_W-1:0] row_mem [MAX_NONZEROS];
  logic [ELEM_BITS-1:0]      val_mem [MAX_NONZEROS];
  logic [csm_pkg::IDX_W-1:0] row_rd_r;
  logic [ELEM_BITS-1:0]      val_rd_r;

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.cmd == csm_pkg::CMD_ROW && slot_ok_nz) begin
      row_mem[NzIdxW'(in_ch.slot)] <= in_ch.index_value;
    end
    row_rd_r <= row_mem[NzIdxW'(nz_r)];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.cmd == csm_pkg::CMD_VAL && slot_ok_nz) begin
      val_mem[NzIdxW'(in_ch.slot)] <= elem_in;
    end
    val_rd_r <= val_mem[NzIdxW'(nz_r)];
  end

  // C store: written by loads and by the accumulate step, read by the
  // accumulate step and by the result sweep.
  logic                 c_wr_en;
  logic [CIdxW-1:0]     c_wr_addr;
  logic [ELEM_BITS-1:0] c_wr_data;
  logic [CIdxW-1:0]     c_rd_addr;
  logic [CIdxW-1:0]     mac_addr;
  logic [CIdxW-1:0]     emit_addr;
  logic [ELEM_BITS-1:0] c_rd;
  logic                 load_c;
  logic                 in_acc_state;
  logic                 emit_state;

  assign load_c       = in_acc && in_ch.cmd == csm_pkg::CMD_WR_C && slot_ok_elem;
  assign in_acc_state = (state_r == S_ACC);
  assign emit_state   = (state_r == S_ERD) || (state_r == S_EOUT);
  assign mac_addr     = CIdxW'(row_r * DIM + j_r);
  assign emit_addr    = CIdxW'(e_row_r * DIM + e_col_r);
  assign c_wr_en      = load_c || in_acc_state;
  assign c_wr_addr    = in_acc_state ? mac_addr : CIdxW'(in_ch.slot);
  assign c_wr_data    = in_acc_state ? c_rd + prod_r : elem_in;
  assign c_rd_addr    = emit_state ? emit_addr : mac_addr;

  csm_c_store #(
    .DIM       (DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_c_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (c_wr_en),
    .wr_addr (c_wr_addr),
    .wr_data (c_wr_data),
    .rd_addr (c_rd_addr),
    .rd_data (c_rd)
  );

  logic emit_last;
  assign emit_last = (e_row_r == RowW'(DIM - 1)) && (e_col_r == RowW'(DIM - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      nz_r        <= '0;
      end_r       <= '0;
      lim_r       <= '0;
      j_r         <= '0;
      row_r       <= '0;
      a_r         <= '0;
      prod_r      <= '0;
      e_row_r     <= '0;
      e_col_r     <= '0;
      c_row_r     <= '0;
      c_col_r     <= '0;
      c_value_r   <= '0;
      last_r      <= 1'b0;
    end else begin
      // The result sweep refills the output register itself when it is taken.
      if (out_valid_r && out_ch.ready && state_r != S_EOUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_ch.cmd == csm_pkg::CMD_RUN) begin
            lim_r   <= lim_in;
            k_r     <= '0;
            state_r <= S_COL;
          end
        end
        S_COL: begin
          nz_r    <= ptr_rd;
          state_r <= S_END;
        end
        S_END: begin
          end_r   <= (ptr_rd < lim_r) ? ptr_rd : lim_r;
          state_r <= S_NZ;
        end
        S_NZ: begin
          if (nz_r < end_r) begin
            state_r <= S_LOAD;
          end else if (k_r == PtrIdxW'(DIM - 1)) begin
            e_row_r <= '0;
            e_col_r <= '0;
            state_r <= S_ERD;
          end else begin
            k_r     <= k_r + PtrIdxW'(1);
            state_r <= S_COL;
          end
        end
        S_LOAD: begin
          // A nonzero whose row lies outside the matrix is passed over.
          if (row_rd_r >= DimIdx) begin
            nz_r    <= nz_r + csm_pkg::IDX_W'(1);
            state_r <= S_NZ;
          end else begin
            row_r   <= RowW'(row_rd_r);
            a_r     <= val_rd_r;
            j_r     <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= ELEM_BITS'(a_r * b_rd_r);
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (j_r == RowW'(DIM - 1)) begin
            nz_r    <= nz_r + csm_pkg::IDX_W'(1);
            state_r <= S_NZ;
          end else begin
            j_r     <= j_r + RowW'(1);
            state_r <= S_RD;
          end
        end
        S_ERD: begin
          state_r <= S_EOUT;
        end
        S_EOUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            c_row_r     <= csm_pkg::CROW_W'(e_row_r);
            c_col_r     <= csm_pkg::CCOL_W'(e_col_r);
            c_value_r   <= csm_pkg::CVAL_W'(c_rd);
            last_r      <= emit_last;
            if (emit_last) begin
              state_r <= S_IDLE;
            end else begin
              if (e_col_r == RowW'(DIM - 1)) begin
                e_col_r <= '0;
                e_row_r <= e_row_r + RowW'(1);
              end else begin
                e_col_r <= e_col_r + RowW'(1);
              end
              state_r <= S_ERD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.c_row   = c_row_r;
  assign out_ch.c_col   = c_col_r;
  assign out_ch.c_value = c_value_r;
  assign out_ch.last    = last_r;

endmodule

`default_nettype wire
